[rtl/lru_page_replacement_top_defines.svh]
// Assertion macros shared by the LRU page replacement RTL.
// Depends on nothing; each using module provides clk and rst_n.
`ifndef LRU_PAGE_REPLACEMENT_TOP_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_TOP_DEFINES_SVH

// A property that must hold at every clock edge out of reset.
`define LRUPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define LRUPR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define LRUPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/lrupr_pkg.sv]
// Shared constants for the LRU page replacement block.
// Depends on nothing; used by the top level and the frame store.
package lrupr_pkg;

  // Default sizing of the frame table.
  localparam int FRAMES_DEF     = 16;
  localparam int PAGE_WIDTH_DEF = 16;
  localparam int TIME_WIDTH_DEF = 32;

  // Fixed field widths on the ports.
  localparam int CFG_W       = 5;
  localparam int PAGE_FLD_W  = 16;
  localparam int FIDX_FLD_W  = 4;
  localparam int FAULT_W     = 32;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_FLD_W   = 1 + FIDX_FLD_W + 1 + PAGE_FLD_W + FAULT_W;
  localparam int OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  // Reset value of the frame count register.
  localparam logic [CFG_W-1:0] NUM_FRAMES_RST = CFG_W'(16);

endpackage

[rtl/lrupr_frame_store.sv]
// Frame table memory: one write port, one read port, registered read data.
// Depends on lrupr_pkg for its default sizing; sized by the top level of the LRU page replacement block.
module lrupr_frame_store #(
  parameter int DEPTH = lrupr_pkg::FRAMES_DEF,
  parameter int AW    = 4,
  parameter int DW    = lrupr_pkg::PAGE_WIDTH_DEF + lrupr_pkg::TIME_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/lru_page_replacement_top.sv]
// LRU page replacement unit: one page reference in, one hit/fault result out.
// Depends on lrupr_pkg, lrupr_frame_store and lru_page_replacement_top_defines.svh.
//
// Each request carries a page number; each result reports hit or fault, the frame
// that now holds the page, the evicted page if any and the running fault count.
// Pages and last-use stamps live in one synchronous frame table that is scanned
// one entry per cycle across the active frames. A request is accepted, the
// table is read entry by entry, the read data of the last entry is awaited,
// and the write-back then also loads the result. A new request is taken while
// the previous result still waits on the output. The table needs no clearing
// after reset; the fill count keeps unwritten frames out of every decision.
// Write cfg_wdata only while no request is in flight.
`include "lru_page_replacement_top_defines.svh"

module lru_page_replacement_top #(
  parameter int FRAMES     = lrupr_pkg::FRAMES_DEF,
  parameter int PAGE_WIDTH = lrupr_pkg::PAGE_WIDTH_DEF,
  parameter int TIME_WIDTH = lrupr_pkg::TIME_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration: num_frames.
  input  logic                                cfg_we,
  input  logic [lrupr_pkg::CFG_W-1:0]         cfg_wdata,
  // Request: [15:0] page_number.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lrupr_pkg::IN_TDATA_W-1:0]    in_tdata,
  // Result: [0] hit, [4:1] frame_index, [5] evicted_valid,
  // [21:6] evicted_page, [53:22] fault_total, [55:54] zero.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lrupr_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W  = $clog2(FRAMES + 1);
  localparam int NW     = (CNT_W > lrupr_pkg::CFG_W) ? CNT_W : lrupr_pkg::CFG_W;
  localparam int PW     = PAGE_WIDTH;
  localparam int TW     = TIME_WIDTH;
  localparam int DW     = PW + TW;
  localparam int FW     = lrupr_pkg::FAULT_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE} state_t;

  state_t                         state_r;
  logic [lrupr_pkg::CFG_W-1:0]    num_frames_r;
  logic [NW-1:0]                  filled_r;
  logic [TW-1:0]                  time_r;
  logic [FW-1:0]                  fault_r;

  // Per-request working registers.
  logic [PW-1:0]                  page_r;
  logic [NW-1:0]                  n_r;
  logic [NW-1:0]                  valid_r;
  logic [NW-1:0]                  iss_r;
  logic                           rdv_r;
  logic [NW-1:0]                  rdidx_r;
  logic                           found_r;
  logic [FIDX_W-1:0]              slot_r;
  logic [FIDX_W-1:0]              best_idx_r;
  logic [TW-1:0]                  best_time_r;
  logic [PW-1:0]                  best_page_r;

  logic                           out_tvalid_r;
  logic [lrupr_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  logic [NW-1:0]                  num_ext;
  logic [NW-1:0]                  n_eff;
  logic [NW-1:0]                  valid_eff;
  logic [PW+15:0]                 in_page_wide;
  logic [PW-1:0]                  in_page;
  logic                           in_accept;
  logic                           rd_en;
  logic [DW-1:0]                  rd_data;
  logic [PW-1:0]                  rd_page;
  logic [TW-1:0]                  rd_time;
  logic                           rd_match;
  logic                           rd_older;
  logic                           scan_last;
  logic                           out_load;
  logic [FIDX_W-1:0]              wr_slot;
  logic                           fill;
  logic                           ev_valid;
  logic [PW+15:0]                 ev_page_wide;
  logic [FIDX_W+3:0]              slot_wide;
  logic [FW-1:0]                  fault_nxt;
  logic [TW-1:0]                  time_nxt;
  logic [NW-1:0]                  filled_nxt;

  // Active frame count clamped to 1..FRAMES, and the searchable frame count.
  assign num_ext   = NW'(num_frames_r);
  assign n_eff     = (num_ext == '0) ? NW'(1) :
                     ((num_ext > NW'(FRAMES)) ? NW'(FRAMES) : num_ext);
  assign valid_eff = (filled_r < n_eff) ? filled_r : n_eff;

  // Page field masked or extended to the table's page width.
  assign in_page_wide = (PW + 16)'(in_tdata[lrupr_pkg::PAGE_FLD_W-1:0]);
  assign in_page      = in_page_wide[PW-1:0];

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;

  // Table read issue: one entry per cycle across the active frames.
  assign rd_en = (state_r == S_SCAN) && (iss_r < n_r);

  lrupr_frame_store #(
    .DEPTH (FRAMES),
    .AW    (FIDX_W),
    .DW    (DW)
  ) u_store (
    .clk     (clk),
    .wr_en   (out_load),
    .wr_addr (wr_slot),
    .wr_data ({time_r, page_r}),
    .rd_en   (rd_en),
    .rd_addr (iss_r[FIDX_W-1:0]),
    .rd_data (rd_data)
  );

  // Compare the entry that just came back from the table.
  assign rd_page   = rd_data[PW-1:0];
  assign rd_time   = rd_data[PW +: TW];
  assign rd_match  = rdv_r && !found_r && (rdidx_r < valid_r) && (rd_page == page_r);
  assign rd_older  = rdv_r && ((rdidx_r == '0) || (rd_time < best_time_r));
  assign scan_last = rdv_r && (rdidx_r == (n_r - NW'(1)));

  // Write-back decision: hit, fill of a free frame, or replacement of the oldest.
  assign out_load = (state_r == S_WRITE) && (!out_tvalid_r || out_tready);
  assign fill     = !found_r && (filled_r < n_r);
  assign ev_valid = !found_r && !fill;

  always_comb begin
    if (found_r) begin
      wr_slot = slot_r;
    end else if (fill) begin
      wr_slot = filled_r[FIDX_W-1:0];
    end else begin
      wr_slot = best_idx_r;
    end
  end

  assign ev_page_wide = ev_valid ? (PW + 16)'(best_page_r) : '0;
  assign slot_wide    = (FIDX_W + 4)'(wr_slot);
  assign fault_nxt    = (!found_r && (fault_r != '1)) ? fault_r + FW'(1) : fault_r;
  assign time_nxt     = (time_r != '1) ? time_r + TW'(1) : time_r;
  assign filled_nxt   = fill ? filled_r + NW'(1) : filled_r;

  // Control sequencer, scan trackers and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      num_frames_r <= lrupr_pkg::NUM_FRAMES_RST;
      filled_r     <= '0;
      time_r       <= '0;
      fault_r      <= '0;
      iss_r        <= '0;
      rdv_r        <= 1'b0;
      found_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_frames_r <= cfg_wdata;
      end

      rdv_r   <= rd_en;
      rdidx_r <= iss_r;

      // A new result replaces the one taken in the same cycle.
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            page_r  <= in_page;
            n_r     <= n_eff;
            valid_r <= valid_eff;
            iss_r   <= '0;
            found_r <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            iss_r <= iss_r + NW'(1);
          end
          if (rd_match) begin
            found_r <= 1'b1;
            slot_r  <= rdidx_r[FIDX_W-1:0];
          end
          if (rd_older) begin
            best_idx_r  <= rdidx_r[FIDX_W-1:0];
            best_time_r <= rd_time;
            best_page_r <= rd_page;
          end
          if (scan_last) begin
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (out_load) begin
            filled_r     <= filled_nxt;
            time_r       <= time_nxt;
            fault_r      <= fault_nxt;
            out_tdata_r  <= {2'b00, fault_nxt, ev_page_wide[15:0], ev_valid,
                             slot_wide[3:0], found_r};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Checks on the sequencer and the bookkeeping.
  `LRUPR_ASSERT(a_fill_bound, filled_r <= NW'(FRAMES), "fill count beyond frame table depth")
  `LRUPR_ASSERT_NEXT(a_accept_scan, in_accept, (state_r == S_SCAN) && !found_r, "request did not start a clean scan")
  `LRUPR_ASSERT_IMPL(a_hit_no_evict, out_load && found_r, !ev_valid, "hit reported an eviction")
  `LRUPR_ASSERT_NEXT(a_fault_mono, out_load, fault_r >= $past(fault_r), "fault count went backwards")
  `LRUPR_ASSERT_IMPL(a_write_quiet, state_r == S_WRITE, !rdv_r && !rd_en, "table read active during write-back")

endmodule

[dv/lru_page_replacement_top_test.sv]
// Self-checking testbench for the LRU page replacement unit.
// It depends on lrupr_pkg and lru_page_replacement_top. A built-in frame-table predictor
// checks every result field while both stream sides idle and stall at random.
`timescale 1ns / 100ps

module lru_page_replacement_top_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;

  // One expected page reference outcome.
  typedef struct packed {
    logic        hit;
    logic [3:0]  frame;
    logic        ev_valid;
    logic [15:0] ev_page;
    logic [31:0] faults;
  } page_result_t;

  logic                              clk        = 1'b0;
  logic                              rst_n      = 1'b0;
  logic                              cfg_we     = 1'b0;
  logic [lrupr_pkg::CFG_W-1:0]       cfg_wdata  = '0;
  logic                              in_tvalid  = 1'b0;
  logic                              in_tready;
  // Request: [15:0] page_number.
  logic [lrupr_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  // Result: [0] hit, [4:1] frame_index, [5] evicted_valid,
  // [21:6] evicted_page, [53:22] fault_total, [55:54] zero.
  logic [lrupr_pkg::OUT_TDATA_W-1:0] out_tdata;

  logic [15:0]  page_q[$];
  page_result_t expected_q[$];
  int           issued_cnt = 0;
  int           seen_cnt   = 0;
  int           error_cnt  = 0;
  int           cycle_cnt  = 0;
  logic         rx_hold    = 1'b0;

  // Predictor copy of the frame table and its counters.
  logic [15:0]  pg_tbl[16];
  logic [31:0]  stamp_tbl[16];
  int           filled     = 0;
  logic [31:0]  ref_clock  = '0;
  logic [31:0]  fault_cnt  = '0;
  logic [4:0]   frames_reg = lrupr_pkg::NUM_FRAMES_RST;

  // Neither side idles while this many results are in this window.
  wire calm = (seen_cnt >= 700) && (seen_cnt < 850);

  lru_page_replacement_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // Applies one page reference to the predicted frame table.
  function automatic page_result_t reference_page(input logic [15:0] page);
    page_result_t r;
    int           n;
    int           live;
    int           slot;
    bit           found;
    n = (frames_reg == 0) ? 1 : ((frames_reg > 16) ? 16 : int'(frames_reg));
    live = (filled < n) ? filled : n;
    slot = 0;
    found = 1'b0;
    r = '0;
    for (int i = 0; i < live; i++) begin
      if (!found && pg_tbl[i] == page) begin
        slot = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      if (filled < n) begin
        slot = filled;
        filled++;
      end else begin
        // Oldest stamp among the active frames; ties keep the lowest index.
        for (int i = 1; i < n; i++) begin
          if (stamp_tbl[i] < stamp_tbl[slot]) slot = i;
        end
        r.ev_valid = 1'b1;
        r.ev_page = pg_tbl[slot];
      end
      pg_tbl[slot] = page;
      if (fault_cnt != '1) fault_cnt++;
    end
    stamp_tbl[slot] = ref_clock;
    if (ref_clock != '1) ref_clock++;
    r.hit = found;
    r.frame = 4'(slot);
    r.faults = fault_cnt;
    return r;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      error_cnt++;
    end
  endfunction

  // Request driver: takes the next pending page, idling at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (page_q.size() > 0 && (calm || $urandom_range(99) >= 17)) begin
        in_tvalid <= 1'b1;
        in_tdata <= page_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: stalls at random and during the long hold-off.
  always @(posedge clk) begin
    if (!rst_n || rx_hold) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 17);
    end
  end

  // Tracks register writes and predicts every accepted request.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) frames_reg = cfg_wdata;
      if (in_tvalid && in_tready) expected_q.push_back(reference_page(in_tdata));
    end
  end

  // Compares each result with the oldest prediction.
  always @(posedge clk) begin : result_check
    page_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen_cnt++;
      if (expected_q.size() == 0) begin
        $error("unexpected result 0x%0h with no request outstanding", out_tdata);
        error_cnt++;
      end else begin
        want = expected_q.pop_front();
        check_field("hit", want.hit, out_tdata[0]);
        check_field("frame_index", want.frame, out_tdata[4:1]);
        check_field("evicted_valid", want.ev_valid, out_tdata[5]);
        check_field("evicted_page", want.ev_page, out_tdata[21:6]);
        check_field("fault_total", want.faults, out_tdata[53:22]);
        check_field("padding", 0, out_tdata[lrupr_pkg::OUT_TDATA_W-1:54]);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Long receiver hold-off so the block fills up and backs up its input.
  initial begin : rx_holdoff
    do @(posedge clk); while (seen_cnt < 400);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic push_page(input logic [15:0] page);
    page_q.push_back(page);
    issued_cnt++;
  endtask

  // Returns at a rising edge once every issued request has its result.
  task automatic wait_idle();
    do @(posedge clk); while (seen_cnt != issued_cnt);
  endtask

  task automatic set_frames(input logic [lrupr_pkg::CFG_W-1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Stimulus: directed corner cases, then random phases over many frame counts.
  initial begin : stimulus
    logic [4:0]  phase_frames[13];
    logic [15:0] pool[$];
    int          n;
    int          pool_size;
    int          len;
    phase_frames = '{5'd16, 5'd1, 5'd8, 5'd3, 5'd20, 5'd12, 5'd5, 5'd16, 5'd2, 5'd7,
                     5'd16, 5'd10, 5'd0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Fill four frames, hit, then evict by age.
    set_frames(5'd4);
    push_page(16'h0000);
    push_page(16'hFFFF);
    push_page(16'h8000);
    push_page(16'h0001);
    push_page(16'h0000);
    push_page(16'h1234);
    push_page(16'hFFFF);
    push_page(16'h0001);
    push_page(16'h7FFE);
    // Count lowered in use: the page held in frame three is no longer seen.
    set_frames(5'd2);
    push_page(16'h0001);
    push_page(16'h1234);
    // A count of zero behaves as one frame.
    set_frames(5'd0);
    push_page(16'hAAAA);
    push_page(16'hAAAA);
    push_page(16'h0000);
    // Counts above the table size behave as the full table.
    set_frames(5'd31);
    push_page(16'h5555);
    push_page(16'hFFFF);
    push_page(16'h0001);
    set_frames(5'd17);
    push_page(16'h0000);
    push_page(16'h8000);

    // Random phases: mostly a small working set per phase so hits and
    // evictions are frequent, plus some fully random pages.
    foreach (phase_frames[p]) begin
      set_frames(phase_frames[p]);
      n = (phase_frames[p] == 0) ? 1 : ((phase_frames[p] > 16) ? 16 : phase_frames[p]);
      pool_size = $urandom_range(n + 4, n / 2 + 1);
      pool.delete();
      repeat (pool_size) pool.push_back(16'($urandom_range(65535)));
      len = $urandom_range(90, 80);
      repeat (len) begin
        if ($urandom_range(99) < 10) push_page(16'($urandom_range(65535)));
        else push_page(pool[$urandom_range(pool_size - 1)]);
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d predicted results never arrived", expected_q.size());
      error_cnt++;
    end
    if (error_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/lrupr_pkg.sv
rtl/lrupr_frame_store.sv
rtl/lru_page_replacement_top.sv
dv/lru_page_replacement_top_test.sv
